// ===== design/dmc_pkg.sv =====
`default_nettype none
package dmc_pkg;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 30;
    localparam int REG_W      = 5;
    localparam int CNT_W      = 32;
    localparam int LINE_OUT_W = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd1;

    localparam logic [REG_W-1:0] CACHE_LOG2_RST = 5'd10;
    localparam logic [REG_W-1:0] BLOCK_LOG2_RST = 5'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LINE,
        S_MOD,
        S_READ,
        S_CMP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic line_load;
        logic mod_step;
        logic rd_en;
        logic clr_en;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/dmc_ram.sv =====
`default_nettype none
module dmc_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/dmc_ctrl.sv =====
`default_nettype none
module dmc_ctrl #(
    parameter bit IS_POW2 = 1'b1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire dmc_pkg::t_sts i_sts,
    output dmc_pkg::t_cmd      o_cmd
);

    import dmc_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.accept   = i_valid;
                if (i_valid) begin
                    n_state = S_LINE;
                end
            end
            S_LINE: begin
                cmd.line_load = 1'b1;
                n_state       = IS_POW2 ? S_READ : S_MOD;
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                // hold the lookup until the output register can take it
                if (i_sts.out_free) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_cmd = cmd;

endmodule
`default_nettype wire

// ===== design/dmc_dp.sv =====
`default_nettype none
module dmc_dp #(
    parameter int MAX_LINES = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dmc_pkg::t_cmd                       i_cmd,
    output dmc_pkg::t_sts                            o_sts,
    input  wire logic                                i_cfg_we,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [dmc_pkg::REG_W-1:0]           i_cfg_data,
    input  wire logic signed [dmc_pkg::ADDR_W-1:0]   i_address_delta,
    input  wire logic                                i_stall,
    output logic                                     o_valid,
    output logic                                     o_hit,
    output logic [dmc_pkg::ADDR_W-1:0]               o_load_address,
    output logic [dmc_pkg::LINE_OUT_W-1:0]           o_line_index,
    output logic [dmc_pkg::CNT_W-1:0]                o_hit_total,
    output logic [dmc_pkg::CNT_W-1:0]                o_miss_total
);

    import dmc_pkg::*;

    localparam int  LW        = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam bit  IS_POW2   = ((MAX_LINES & (MAX_LINES - 1)) == 0);
    localparam int  MOD_CNT_W = 2;
    localparam int  RAM_W     = TAG_W + 1;

    // floor(2^32 / MAX_LINES): the quotient estimate is at most one low
    localparam logic [2*ADDR_W-1:0] RECIP_FULL =
        ((2*ADDR_W)'(1) << ADDR_W) / (2*ADDR_W)'(MAX_LINES);
    localparam logic [ADDR_W-1:0]   RECIP      = RECIP_FULL[ADDR_W-1:0];
    localparam logic [ADDR_W-1:0]   LINES_W    = ADDR_W'(MAX_LINES);

    localparam logic [MOD_CNT_W-1:0] MOD_MUL = 2'd0;
    localparam logic [MOD_CNT_W-1:0] MOD_SUB = 2'd1;
    localparam logic [MOD_CNT_W-1:0] MOD_FIX = 2'd2;

    logic [REG_W-1:0]     r_cache_log2;
    logic [REG_W-1:0]     r_block_log2;
    logic [ADDR_W-1:0]    r_addr;
    logic [TAG_W-1:0]     r_tag;
    logic [ADDR_W-1:0]    r_num;
    logic [ADDR_W-1:0]    r_quot;
    logic [LW-1:0]        r_rem;
    logic [MOD_CNT_W-1:0] r_mod_cnt;
    logic [LW-1:0]        r_clr;
    logic [CNT_W-1:0]     r_hit_cnt;
    logic [CNT_W-1:0]     r_miss_cnt;
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [ADDR_W-1:0]    r_out_addr;
    logic [LW-1:0]        r_out_line;

    logic [ADDR_W-1:0]    offset_mask;
    logic [ADDR_W-1:0]    raw_line;
    logic [ADDR_W-1:0]    tag_shift;
    logic [2*ADDR_W-1:0]  mul_full;
    logic [ADDR_W-1:0]    mod_sub;
    logic [ADDR_W-1:0]    mod_fix;
    logic                 out_free;
    logic                 hit;
    logic [RAM_W-1:0]     ram_rdata;
    logic                 ram_we;
    logic [LW-1:0]        ram_waddr;
    logic [RAM_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]    line_ext;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_log2 <= CACHE_LOG2_RST;
            r_block_log2 <= BLOCK_LOG2_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CACHE_LOG2: r_cache_log2 <= i_cfg_data;
                CFG_BLOCK_LOG2: r_block_log2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign offset_mask = ~({ADDR_W{1'b1}} << r_cache_log2);
    assign raw_line    = (r_addr & offset_mask) >> r_block_log2;
    assign tag_shift   = r_addr >> r_cache_log2;

    // line remainder when the line count is not a power of two:
    // reciprocal multiply, subtract, then one correcting subtract
    assign mul_full = {{ADDR_W{1'b0}}, r_num} * {{ADDR_W{1'b0}}, RECIP};
    assign mod_sub  = r_num - r_quot * LINES_W;
    assign mod_fix  = (r_num >= LINES_W) ? r_num - LINES_W : r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.accept) begin
            r_addr <= r_addr + $unsigned(i_address_delta);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.line_load) begin
            r_tag     <= tag_shift[TAG_W-1:0];
            r_num     <= raw_line;
            r_rem     <= IS_POW2 ? raw_line[LW-1:0] : '0;
            r_mod_cnt <= '0;
        end else if (i_cmd.mod_step) begin
            case (r_mod_cnt)
                MOD_MUL: r_quot <= mul_full[2*ADDR_W-1:ADDR_W];
                MOD_SUB: r_num  <= mod_sub;
                default: r_rem  <= mod_fix[LW-1:0];
            endcase
            r_mod_cnt <= r_mod_cnt + 1'b1;
        end
        if (i_cmd.commit) begin
            r_out_hit  <= hit;
            r_out_addr <= r_addr;
            r_out_line <= r_rem;
        end
    end

    // clearing pass over the tag store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign hit = ram_rdata[TAG_W] && (ram_rdata[TAG_W-1:0] == r_tag);

    always_comb begin
        if (i_cmd.clr_en) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            ram_we    = i_cmd.commit && !hit;
            ram_waddr = r_rem;
            ram_wdata = {1'b1, r_tag};
        end
    end

    dmc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_LINES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_rem),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (hit) begin
                    if (r_hit_cnt != {CNT_W{1'b1}}) begin
                        r_hit_cnt <= r_hit_cnt + 1'b1;
                    end
                end else if (r_miss_cnt != {CNT_W{1'b1}}) begin
                    r_miss_cnt <= r_miss_cnt + 1'b1;
                end
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    assign o_sts.clr_last = (r_clr == LW'(MAX_LINES - 1));
    assign o_sts.mod_last = (r_mod_cnt == MOD_FIX);
    assign o_sts.out_free = out_free;

    assign line_ext       = {{(ADDR_W-LW){1'b0}}, r_out_line};
    assign o_valid        = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_load_address = r_out_addr;
    assign o_line_index   = line_ext[LINE_OUT_W-1:0];
    assign o_hit_total    = r_hit_cnt;
    assign o_miss_total   = r_miss_cnt;

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> out_free)
        else $error("result overwrites a waiting result");

    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_en |-> !i_cmd.commit && !i_cmd.accept)
        else $error("lookup overlaps tag store clearing");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed lookup not presented");

endmodule
`default_nettype wire

// ===== design/direct_mapped_cache_hit_counter_top.sv =====
// Direct-mapped cache hit counter.
// Input channel (i_valid / o_stall): one request per load, carrying the signed
// address delta from the previous load. The running address starts at zero.
// Output channel (o_valid / i_stall): one result per request with the hit flag,
// the load address, the selected line and the saturating hit and miss totals.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0: log2
// cache bytes, 1: log2 block bytes); write only while no request is in flight.
// A request accepted in the idle state loads its line and tag, reads the tag
// store and compares before its result is registered; when MAX_LINES is not a
// power of two, the line remainder adds a reciprocal multiply, a subtract and a
// correcting subtract. One request is in flight at a time; the next one is
// taken once the controller is back in idle after the result is registered.
// The tag store is read, compared and, on a miss, written with the new tag.
// Reset clears the address, counters and output valid, then a clearing pass
// zeroes all MAX_LINES tag store entries; o_stall stays high during that pass.
// A stalled result holds; the next request can already be looked up but waits
// for the output register before it completes.
`default_nettype none
module direct_mapped_cache_hit_counter_top #(
    parameter int MAX_LINES = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [dmc_pkg::REG_W-1:0]           i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [dmc_pkg::ADDR_W-1:0]   i_address_delta,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_hit,
    output logic [dmc_pkg::ADDR_W-1:0]               o_load_address,
    output logic [dmc_pkg::LINE_OUT_W-1:0]           o_line_index,
    output logic [dmc_pkg::CNT_W-1:0]                o_hit_total,
    output logic [dmc_pkg::CNT_W-1:0]                o_miss_total
);

    import dmc_pkg::*;

    localparam bit IS_POW2 = ((MAX_LINES & (MAX_LINES - 1)) == 0);

    t_cmd cmd;
    t_sts sts;

    dmc_ctrl #(
        .IS_POW2 (IS_POW2)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dmc_dp #(
        .MAX_LINES (MAX_LINES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_address_delta (i_address_delta),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_load_address  (o_load_address),
        .o_line_index    (o_line_index),
        .o_hit_total     (o_hit_total),
        .o_miss_total    (o_miss_total)
    );

    assign o_stall = !cmd.in_ready;

endmodule
`default_nettype wire
